// ===== hdl/mrp_pkg.sv =====
// Shared constants, register indexes and helper functions of the median edge residual predictor.
package mrp_pkg;

    // Default depth of the previous-row store
    localparam int MAX_WIDTH_DEFAULT = 4096;

    // Field widths
    localparam int SAMPLE_W       = 16;
    localparam int VALUE_W        = 17;
    localparam int GRAD_W         = 19;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int PLANE_WIDTH_W  = 13;
    localparam int PLANE_HEIGHT_W = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_SAMPLES = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SAMPLE     = 3'd4;

    // Register values after reset
    localparam logic [PLANE_WIDTH_W-1:0]  PLANE_WIDTH_RESET  = 13'd4096;
    localparam logic [PLANE_HEIGHT_W-1:0] PLANE_HEIGHT_RESET = 16'd1;
    localparam logic [SAMPLE_W-1:0]       MAX_SAMPLE_RESET   = 16'd255;

    // Gradient activity thresholds and classes
    localparam logic [GRAD_W-1:0] ACT_LIMIT_LOW  = 19'd4;
    localparam logic [GRAD_W-1:0] ACT_LIMIT_MID  = 19'd16;
    localparam logic [GRAD_W-1:0] ACT_LIMIT_HIGH = 19'd64;
    localparam logic [1:0] ACT_FLAT   = 2'd0;
    localparam logic [1:0] ACT_LOW    = 2'd1;
    localparam logic [1:0] ACT_MEDIUM = 2'd2;
    localparam logic [1:0] ACT_HIGH   = 2'd3;

    // Stored 16-bit sample as a 17-bit signed operand
    function automatic logic signed [VALUE_W-1:0] read_sample(
        input logic [SAMPLE_W-1:0] raw,
        input logic                sgn
    );
        logic signed [VALUE_W-1:0] ext;
        ext = sgn ? $signed({raw[SAMPLE_W-1], raw}) : $signed({1'b0, raw});
        return ext;
    endfunction

    // Four-level gradient class
    function automatic logic [1:0] classify(input logic [GRAD_W-1:0] grad);
        logic [1:0] act;
        if (grad < ACT_LIMIT_LOW)
            act = ACT_FLAT;
        else if (grad < ACT_LIMIT_MID)
            act = ACT_LOW;
        else if (grad < ACT_LIMIT_HIGH)
            act = ACT_MEDIUM;
        else
            act = ACT_HIGH;
        return act;
    endfunction

endpackage

// ===== hdl/med_residual_predictor.sv =====
// Median edge residual predictor: row store, neighbour registers, predictor and result register.
// Takes one item per clock in raster order while the result channel is not stalled, and gives
// one result per item. An accepted item sits in the working register while its top neighbour
// is read from the previous-row memory (one write port, one registered read port); from there
// the prediction, residual or clamped sample and gradient class are computed into the result
// register whenever that register can advance, so items
// may follow back to back. The clock period is
// set by the left-neighbour loop: stored sample -> median select -> add -> clamp -> left
// register. The store is MAX_WIDTH x 16 bits and needs no clearing pass; a top neighbour is
// only used from the second row on, after it was written. Any configuration write restarts
// the plane at row 0, column 0; end_of_plane marks the last sample of each plane.
module med_residual_predictor #(
    parameter int MAX_WIDTH = mrp_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration write port
    input  logic                                      cfg_write,
    input  logic [mrp_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [mrp_pkg::CFG_DATA_W-1:0]            cfg_data,
    // input channel
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [mrp_pkg::VALUE_W-1:0]        value_in,
    // result channel
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [mrp_pkg::VALUE_W-1:0]        value_out,
    output logic signed [mrp_pkg::VALUE_W-1:0]        prediction,
    output logic [1:0]                                activity,
    output logic                                      end_of_plane
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > mrp_pkg::PLANE_WIDTH_W) ? COL_W + 1
                                                                : mrp_pkg::PLANE_WIDTH_W;
    localparam int SW = mrp_pkg::SAMPLE_W;
    localparam int VW = mrp_pkg::VALUE_W;
    localparam int HW = mrp_pkg::PLANE_HEIGHT_W;

    // Configuration registers
    logic [mrp_pkg::PLANE_WIDTH_W-1:0] plane_width_reg;
    logic [HW-1:0]                     plane_height_reg;
    logic                              signed_samples_reg;
    logic                              decode_mode_reg;
    logic [SW-1:0]                     max_sample_reg;

    // Raster position of the next item
    logic [COL_W-1:0] col_reg, col_next;
    logic [HW-1:0]    row_reg, row_next;

    // Working stage
    logic              s1_valid_reg;
    logic [VW-1:0]     s1_value_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_colnz_reg;
    logic              s1_rownz_reg;
    logic              s1_last_reg;
    logic [SW-1:0]     top_mem_reg;
    logic              byp_reg;
    logic [SW-1:0]     byp_val_reg;

    // Neighbour registers
    logic [SW-1:0] left_reg;
    logic [SW-1:0] ul_reg;

    // Result register
    logic              out_valid_reg;
    logic signed [VW-1:0] value_out_reg;
    logic signed [VW-1:0] pred_out_reg;
    logic [1:0]        act_out_reg;
    logic              eop_out_reg;

    // Previous-row store
    logic [SW-1:0] row_mem [MAX_WIDTH];

    logic accept;
    logic advance;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] col_inc;
    logic [HW-1:0]    h_eff;
    logic [HW:0]      row_inc;
    logic             last_col;
    logic             last_row;

    logic [SW-1:0]           top_raw;
    logic signed [VW-1:0]    a_val, b_val, c_val, mx_val, mn_val, pred_val, rd_val;
    logic signed [VW:0]      pred_wide, d_ac, d_bc, sum_val, clamped, diff_val;
    logic [VW:0]             abs_ac, abs_bc;
    logic [mrp_pkg::GRAD_W-1:0] grad;
    logic [SW-1:0]           stored;
    logic signed [VW-1:0]    result;

    // Handshake
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // Effective plane size and raster stepping
    always_comb
    begin
        if (plane_width_reg == '0)
            w_eff = CMP_W'(1);
        else if (CMP_W'(plane_width_reg) > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = CMP_W'(plane_width_reg);
        h_eff    = (plane_height_reg == '0) ? HW'(1) : plane_height_reg;
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        row_inc  = {1'b0, row_reg} + (HW+1)'(1);
        last_col = col_inc >= w_eff;
        last_row = row_inc >= {1'b0, h_eff};
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_inc[HW-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    // Median edge prediction, gradient class and result
    always_comb
    begin
        top_raw = byp_reg ? byp_val_reg : top_mem_reg;
        a_val = s1_colnz_reg ? mrp_pkg::read_sample(left_reg, signed_samples_reg) : '0;
        b_val = s1_rownz_reg ? mrp_pkg::read_sample(top_raw, signed_samples_reg) : '0;
        c_val = (s1_colnz_reg && s1_rownz_reg)
              ? mrp_pkg::read_sample(ul_reg, signed_samples_reg) : '0;
        mx_val    = (a_val > b_val) ? a_val : b_val;
        mn_val    = (a_val < b_val) ? a_val : b_val;
        pred_wide = $signed({a_val[VW-1], a_val}) + $signed({b_val[VW-1], b_val})
                  - $signed({c_val[VW-1], c_val});
        if (c_val >= mx_val)
            pred_val = mn_val;
        else if (c_val <= mn_val)
            pred_val = mx_val;
        else
            pred_val = pred_wide[VW-1:0];

        d_ac   = $signed({a_val[VW-1], a_val}) - $signed({c_val[VW-1], c_val});
        d_bc   = $signed({b_val[VW-1], b_val}) - $signed({c_val[VW-1], c_val});
        abs_ac = d_ac[VW] ? (VW+1)'(-d_ac) : (VW+1)'(d_ac);
        abs_bc = d_bc[VW] ? (VW+1)'(-d_bc) : (VW+1)'(d_bc);
        grad   = {1'b0, abs_ac} + {1'b0, abs_bc};

        // decode: prediction plus residual, clamped to 0..max_sample
        sum_val = $signed({pred_val[VW-1], pred_val})
                + $signed({s1_value_reg[VW-1], s1_value_reg});
        if (sum_val < 0)
            clamped = '0;
        else if (sum_val > $signed({2'b00, max_sample_reg}))
            clamped = $signed({2'b00, max_sample_reg});
        else
            clamped = sum_val;

        // encode: sample minus prediction
        rd_val   = mrp_pkg::read_sample(s1_value_reg[SW-1:0], signed_samples_reg);
        diff_val = $signed({rd_val[VW-1], rd_val}) - $signed({pred_val[VW-1], pred_val});

        if (decode_mode_reg)
        begin
            stored = clamped[SW-1:0];
            result = clamped[VW-1:0];
        end
        else
        begin
            stored = s1_value_reg[SW-1:0];
            result = diff_val[VW-1:0];
        end
    end

    // Configuration registers and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg    <= mrp_pkg::PLANE_WIDTH_RESET;
            plane_height_reg   <= mrp_pkg::PLANE_HEIGHT_RESET;
            signed_samples_reg <= 1'b0;
            decode_mode_reg    <= 1'b0;
            max_sample_reg     <= mrp_pkg::MAX_SAMPLE_RESET;
            col_reg            <= '0;
            row_reg            <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mrp_pkg::REG_PLANE_WIDTH:
                    plane_width_reg <= cfg_data[mrp_pkg::PLANE_WIDTH_W-1:0];
                mrp_pkg::REG_PLANE_HEIGHT:   plane_height_reg   <= cfg_data;
                mrp_pkg::REG_SIGNED_SAMPLES: signed_samples_reg <= cfg_data[0];
                mrp_pkg::REG_DECODE_MODE:    decode_mode_reg    <= cfg_data[0];
                mrp_pkg::REG_MAX_SAMPLE:     max_sample_reg     <= cfg_data;
                default:                     ;
            endcase
            // any write restarts the plane
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Working stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            if (accept)
                byp_reg <= s1_valid_reg && (s1_col_reg == col_reg);
        end
    end

    // Working stage payload; a transfer for the column being written takes the new sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= value_in;
            s1_col_reg   <= col_reg;
            s1_colnz_reg <= (col_reg != '0);
            s1_rownz_reg <= (row_reg != '0);
            s1_last_reg  <= last_col && last_row;
            byp_val_reg  <= stored;
        end
    end

    // Previous-row store: read for the incoming item, write back the finished one
    always_ff @(posedge clk)
    begin
        if (accept)
            top_mem_reg <= row_mem[col_reg];
        if (s1_valid_reg && advance)
            row_mem[s1_col_reg] <= stored;
    end

    // Neighbour registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            ul_reg   <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            left_reg <= stored;
            ul_reg   <= top_raw;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            value_out_reg <= result;
            pred_out_reg  <= pred_val;
            act_out_reg   <= mrp_pkg::classify(grad);
            eop_out_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value_out    = value_out_reg;
    assign prediction   = pred_out_reg;
    assign activity     = act_out_reg;
    assign end_of_plane = eop_out_reg;

    // Checks
    a_col_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(col_reg) < w_eff)
        else $error("column counter beyond plane width");

    a_pred_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (pred_val >= mn_val) && (pred_val <= mx_val))
        else $error("prediction outside neighbour range");

    a_decode_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && decode_mode_reg) |->
            (clamped >= 0) && (clamped <= $signed({2'b00, max_sample_reg})))
        else $error("reconstructed sample outside clamp range");

endmodule
